>>> rtl/multi_timer_table_unit_defines.svh
// assertion macros for the timer table unit
// expects clk and rst_n in the scope of each use
`ifndef MULTI_TIMER_TABLE_UNIT_DEFINES_SVH
`define MULTI_TIMER_TABLE_UNIT_DEFINES_SVH

// condition holds in the same cycle
`define MTT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer table assertion failed");

// condition holds in the next cycle
`define MTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer table assertion failed");

`endif

>>> rtl/mtt_pkg.sv
// shared constants and codes for the timer table unit
// no dependencies
`timescale 1ns / 1ps

package mtt_pkg;

  localparam int MAX_TIMERS_DEF = 32;
  localparam int OWNER_BITS_DEF = 16;
  localparam int ID_BITS_DEF    = 16;

  localparam int RES_W    = 10;
  localparam int IVL_W    = 31;
  localparam int ELAPSE_W = 32;
  localparam int PARAM_W  = 32;

  localparam logic [RES_W-1:0]    RES_RESET     = RES_W'(20);
  localparam logic [ELAPSE_W-1:0] ELAPSED_LIMIT = ELAPSE_W'(1000);

  typedef logic [1:0] op_t;
  localparam op_t OP_SET   = 2'd0;
  localparam op_t OP_KILL  = 2'd1;
  localparam op_t OP_RESET = 2'd2;
  localparam op_t OP_TICK  = 2'd3;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_STATUS = 2'd0;
  localparam kind_t KIND_FIRE   = 2'd1;
  localparam kind_t KIND_DONE   = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EXISTS   = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

endpackage

>>> rtl/mtt_if.sv
// request and result channel interfaces for the timer table unit
// depends on mtt_pkg
`timescale 1ns / 1ps

interface mtt_in_if
  import mtt_pkg::*;
#(
  parameter int OWNER_BITS = OWNER_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  op_t                   operation;
  logic [OWNER_BITS-1:0] owner;
  logic [ID_BITS-1:0]    timer_id;
  logic [IVL_W-1:0]      interval_ms;
  logic [PARAM_W-1:0]    user_param;
  logic signed [ELAPSE_W-1:0] elapsed_ms;

  modport source (output valid, operation, owner, timer_id, interval_ms, user_param,
                  elapsed_ms, input ready);
  modport sink (input valid, operation, owner, timer_id, interval_ms, user_param,
                elapsed_ms, output ready);
endinterface

interface mtt_out_if
  import mtt_pkg::*;
#(
  parameter int OWNER_BITS = OWNER_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  kind_t                 kind;
  status_t               status;
  logic [OWNER_BITS-1:0] fire_owner;
  logic [ID_BITS-1:0]    fire_id;
  logic [PARAM_W-1:0]    fire_param;
  logic                  last;

  modport source (output valid, kind, status, fire_owner, fire_id, fire_param, last,
                  input ready);
  modport sink (input valid, kind, status, fire_owner, fire_id, fire_param, last,
                output ready);
endinterface

>>> rtl/multi_timer_table_unit.sv
// timer table unit: top level with sequencer, entry memory and result register
// depends on mtt_pkg, mtt_if.sv and multi_timer_table_unit_defines.svh
`timescale 1ns / 1ps
`include "multi_timer_table_unit_defines.svh"

// Table of up to MAX_TIMERS periodic timers kept packed in an entry memory
// with one write and one read port, oldest in slot 0. One request is taken at
// a time; in_ch.ready is low while it is worked on. Set, kill and reset scan
// the table through one memory read port, each visited slot first addressed,
// then compared; kill then moves each later entry down one slot. A tick walks
// all active entries newest first, each read, given a saturating add, then
// compared and subtracted, with a fire transfer for each due timer and then a
// tick-done transfer. Every request ends with a transfer marked last. No
// clearing pass after reset: only slots below the active count are read.
module multi_timer_table_unit
  import mtt_pkg::*;
#(
  parameter int MAX_TIMERS = MAX_TIMERS_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [RES_W-1:0] cfg_wdata,
  mtt_in_if.sink           in_ch,
  mtt_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(MAX_TIMERS + 1);
  localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int SUM_W = ELAPSE_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TIMERS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRD   = 4'd1;  // lookup: address slot
  localparam logic [3:0] S_SCMP  = 4'd2;  // lookup: compare key
  localparam logic [3:0] S_KRD   = 4'd3;  // kill: address next slot
  localparam logic [3:0] S_KWR   = 4'd4;  // kill: move entry down
  localparam logic [3:0] S_TRD   = 4'd5;  // tick: address slot
  localparam logic [3:0] S_TADD  = 4'd6;  // tick: saturating add
  localparam logic [3:0] S_TCMP  = 4'd7;  // tick: compare and write back
  localparam logic [3:0] S_TDONE = 4'd8;  // tick: queue done result
  localparam logic [3:0] S_EMIT  = 4'd9;  // hand pending result to output reg

  typedef struct packed {
    logic [OWNER_BITS-1:0] owner;
    logic [ID_BITS-1:0]    id;
    logic [IVL_W-1:0]      interval;
    logic [ELAPSE_W-1:0]   elapsed;
    logic [PARAM_W-1:0]    param;
  } entry_t;

  typedef struct packed {
    kind_t                 kind;
    status_t               status;
    logic [OWNER_BITS-1:0] owner;
    logic [ID_BITS-1:0]    id;
    logic [PARAM_W-1:0]    param;
    logic                  last;
  } result_t;

  // entry memory, one write and one registered read port
  entry_t mem [MAX_TIMERS];
  entry_t rdata_r;
  logic [IDX_W-1:0] raddr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  // control state
  logic [3:0]       state_r, state_nxt;
  logic [3:0]       ret_r, ret_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [RES_W-1:0] res_r;
  logic             out_valid_r, out_valid_nxt;

  // request held for the whole operation
  op_t                   op_r;
  logic [OWNER_BITS-1:0] own_r;
  logic [ID_BITS-1:0]    id_r;
  logic [IVL_W-1:0]      ivl_r;
  logic [PARAM_W-1:0]    param_r;
  logic [RES_W-1:0]      dt_r;

  logic [ELAPSE_W-1:0] sum_r, sum_nxt;
  result_t             pend_r, pend_nxt;
  result_t             out_r;

  logic                  accept;
  logic                  out_free;
  logic [IVL_W-1:0]      ivl_raised;
  logic [RES_W-1:0]      dt_in;
  logic                  dt_ok;
  logic [SUM_W-1:0]      sum_wide;
  logic                  key_hit;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // interval raised to the resolution, elapsed falls back to it out of range
  assign ivl_raised = (in_ch.interval_ms >= IVL_W'(res_r)) ? in_ch.interval_ms
                                                           : IVL_W'(res_r);
  assign dt_ok = !in_ch.elapsed_ms[ELAPSE_W-1] && (in_ch.elapsed_ms != '0) &&
                 (ELAPSE_W'(in_ch.elapsed_ms) < ELAPSED_LIMIT);
  assign dt_in = dt_ok ? in_ch.elapsed_ms[RES_W-1:0] : res_r;

  assign sum_wide = SUM_W'(rdata_r.elapsed) + SUM_W'(dt_r);
  assign key_hit  = (rdata_r.owner == own_r) && (rdata_r.id == id_r);

  // kill reads one slot ahead of the slot being filled
  assign raddr = (state_r == S_KRD) ? IDX_W'(idx_r + CNT_ONE) : idx_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    we            = 1'b0;
    waddr         = idx_r[IDX_W-1:0];
    wdata         = rdata_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          if (in_ch.operation == OP_TICK) begin
            if (count_r == '0) begin
              state_nxt = S_TDONE;
            end else begin
              idx_nxt   = count_r - CNT_ONE;
              state_nxt = S_TRD;
            end
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD: begin
        if (idx_r == count_r) begin
          // key not in table
          pend_nxt  = '{KIND_STATUS, ST_NOTFOUND, '0, '0, '0, 1'b1};
          ret_nxt   = S_IDLE;
          state_nxt = S_EMIT;
          if (op_r == OP_SET) begin
            if (count_r >= CNT_MAX) begin
              pend_nxt.status = ST_FULL;
            end else begin
              pend_nxt.status = ST_OK;
              we              = 1'b1;
              waddr           = count_r[IDX_W-1:0];
              wdata           = '{own_r, id_r, ivl_r, '0, param_r};
              count_nxt       = count_r + CNT_ONE;
            end
          end
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (key_hit) begin
          pend_nxt = '{KIND_STATUS, ST_OK, '0, '0, '0, 1'b1};
          ret_nxt  = S_IDLE;
          if (op_r == OP_SET) begin
            pend_nxt.status = ST_EXISTS;
            state_nxt       = S_EMIT;
          end else if (op_r == OP_RESET) begin
            we            = 1'b1;
            wdata.elapsed = '0;
            state_nxt     = S_EMIT;
          end else begin
            state_nxt = S_KRD;
          end
        end else begin
          idx_nxt   = idx_r + CNT_ONE;
          state_nxt = S_SRD;
        end
      end
      S_KRD: begin
        if ((idx_r + CNT_ONE) >= count_r) begin
          count_nxt = count_r - CNT_ONE;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_KWR;
        end
      end
      S_KWR: begin
        we        = 1'b1;
        idx_nxt   = idx_r + CNT_ONE;
        state_nxt = S_KRD;
      end
      S_TRD: begin
        state_nxt = S_TADD;
      end
      S_TADD: begin
        sum_nxt   = sum_wide[ELAPSE_W] ? '1 : sum_wide[ELAPSE_W-1:0];
        state_nxt = S_TCMP;
      end
      S_TCMP: begin
        we = 1'b1;
        if (sum_r >= ELAPSE_W'(rdata_r.interval)) begin
          wdata.elapsed = sum_r - ELAPSE_W'(rdata_r.interval);
          pend_nxt      = '{KIND_FIRE, ST_OK, rdata_r.owner, rdata_r.id, rdata_r.param,
                            1'b0};
          ret_nxt       = (idx_r == '0) ? S_TDONE : S_TRD;
          state_nxt     = S_EMIT;
        end else begin
          wdata.elapsed = sum_r;
          state_nxt     = (idx_r == '0) ? S_TDONE : S_TRD;
        end
        idx_nxt = idx_r - CNT_ONE;
      end
      S_TDONE: begin
        pend_nxt  = '{KIND_DONE, ST_OK, '0, '0, '0, 1'b1};
        ret_nxt   = S_IDLE;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      res_r       <= RES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        res_r <= cfg_wdata;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    pend_r <= pend_nxt;
    if (accept) begin
      op_r    <= in_ch.operation;
      own_r   <= in_ch.owner;
      id_r    <= in_ch.timer_id;
      ivl_r   <= ivl_raised;
      param_r <= in_ch.user_param;
      dt_r    <= dt_in;
    end
    // load the result register on the transfer into it
    if (state_r == S_EMIT && out_free) begin
      out_r <= pend_r;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.status     = out_r.status;
  assign out_ch.fire_owner = out_r.owner;
  assign out_ch.fire_id    = out_r.id;
  assign out_ch.fire_param = out_r.param;
  assign out_ch.last       = out_r.last;

  // table never holds more than its capacity
  `MTT_ASSERT_SAME(a_count_cap, 1'b1, count_r <= CNT_MAX)
  // an accepted request always leaves idle
  `MTT_ASSERT_NEXT(a_accept_busy, accept, state_r != S_IDLE)
  // fire transfers are never the final result of a request
  `MTT_ASSERT_SAME(a_fire_not_last, out_valid_r && out_r.kind == KIND_FIRE, !out_r.last)

endmodule
